/* src/multi_stack_shared_buffer_defines.svh */
// ============================================================================
// multi_stack_shared_buffer_defines.svh - assertion macros
// Shared concurrent assertion forms for the multi-stack shared buffer.
// ============================================================================
`ifndef MULTI_STACK_SHARED_BUFFER_DEFINES_SVH
`define MULTI_STACK_SHARED_BUFFER_DEFINES_SVH

// same-cycle implication
`define MSSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mssb assertion failed");

// next-cycle implication
`define MSSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mssb assertion failed");

`endif

/* src/mssb_pkg.sv */
// ============================================================================
// mssb_pkg - shared types and constants
// Field widths, defaults, command and status codes for the shared stack buffer.
// ============================================================================
package mssb_pkg;

    localparam int NUM_STACKS_DEF = 4;
    localparam int NUM_SLOTS_DEF  = 64;
    localparam int STACK_ID_W     = 2;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 2;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

/* src/mssb_cmd_if.sv */
// ============================================================================
// mssb_cmd_if - command channel
// Valid/ready channel carrying one push or pop transaction.
// ============================================================================
interface mssb_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [mssb_pkg::STACK_ID_W-1:0]     stack_id;
    logic signed [mssb_pkg::VALUE_W-1:0] push_value;

    modport source (output valid, output cmd, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input cmd, input stack_id, input push_value,
                    output ready);
endinterface

/* src/mssb_rsp_if.sv */
// ============================================================================
// mssb_rsp_if - response channel
// Valid/ready channel carrying one status/pop value transaction.
// ============================================================================
interface mssb_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [mssb_pkg::STATUS_W-1:0]       status;
    logic signed [mssb_pkg::VALUE_W-1:0] pop_value;

    modport source (output valid, output status, output pop_value, input ready);
    modport sink   (input valid, input status, input pop_value, output ready);
endinterface

/* src/mssb_link_store.sv */
// ============================================================================
// mssb_link_store - slot link memory
// One write and one registered read per cycle. Per-entry valid bits give the
// reset chain (slot i -> i+1, last -> null); same-edge writes are bypassed.
// ============================================================================
module mssb_link_store #(
    parameter int NUM_SLOTS = mssb_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]        i_rd_addr,
    input  logic                                i_wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]        i_wr_addr,
    input  logic [$clog2(NUM_SLOTS+1)-1:0]      i_wr_data,
    output logic [$clog2(NUM_SLOTS+1)-1:0]      o_rd_data
);
    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int CODE_W = $clog2(NUM_SLOTS+1);
    localparam logic [CODE_W-1:0] NULL_CODE = CODE_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

    logic [CODE_W-1:0] r_mem [NUM_SLOTS];
    logic              r_vld [NUM_SLOTS];
    logic [CODE_W-1:0] r_q;
    logic [IDX_W-1:0]  r_addr;
    logic [CODE_W-1:0] r_byp_data;
    logic              r_q_vld;
    logic              r_byp;
    logic [CODE_W-1:0] rst_code;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_addr     <= i_rd_addr;
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '{default: 1'b0};
            r_q_vld <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
                r_byp   <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign rst_code  = (r_addr == LAST_IDX) ? NULL_CODE : (CODE_W'(r_addr) + CODE_W'(1));
    assign o_rd_data = r_byp ? r_byp_data : (r_q_vld ? r_q : rst_code);

endmodule

/* src/mssb_data_store.sv */
// ============================================================================
// mssb_data_store - slot data memory
// One write and one registered read per cycle, same-edge writes bypassed.
// ============================================================================
module mssb_data_store #(
    parameter int NUM_SLOTS = mssb_pkg::NUM_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_rd_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]        i_rd_addr,
    input  logic                                i_wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]        i_wr_addr,
    input  logic [mssb_pkg::VALUE_W-1:0]        i_wr_data,
    output logic [mssb_pkg::VALUE_W-1:0]        o_rd_data
);
    logic [mssb_pkg::VALUE_W-1:0] r_mem [NUM_SLOTS];
    logic [mssb_pkg::VALUE_W-1:0] r_q;
    logic [mssb_pkg::VALUE_W-1:0] r_byp_data;
    logic                         r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_q;

endmodule

/* src/multi_stack_shared_buffer.sv */
// Several LIFO stacks share NUM_SLOTS slots through a link memory and a free
// list. Each command transaction (push or pop on one stack) gives one
// response transaction: status ok, full (no free slot, or no such stack) or
// empty (stack empty, or no such stack), and the popped value on a good pop.
// One transaction is accepted every cycle unless the response side stalls;
// it passes the command register, then the response register. The rate is
// set by the link memory: the slot a command uses is read at the edge it is
// accepted, and the next command's address is formed from the state updated
// with that read in the following cycle. Link reset values come from per-slot
// valid bits, so the block is usable right after reset with no clearing pass.
`include "multi_stack_shared_buffer_defines.svh"
// ============================================================================
// multi_stack_shared_buffer - top level
// Command register, free-list and stack-top state, response register.
// ============================================================================
module multi_stack_shared_buffer #(
    parameter int NUM_STACKS = mssb_pkg::NUM_STACKS_DEF,
    parameter int NUM_SLOTS  = mssb_pkg::NUM_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mssb_cmd_if.sink     i_cmd,
    mssb_rsp_if.source   o_rsp
);
    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int CODE_W = $clog2(NUM_SLOTS+1);
    localparam int TOP_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int VAL_W  = mssb_pkg::VALUE_W;
    localparam logic [CODE_W-1:0] NULL_CODE = CODE_W'(NUM_SLOTS);

    // command stage
    logic                               r_a_vld;
    mssb_pkg::t_cmd                     r_a_cmd;
    logic [mssb_pkg::STACK_ID_W-1:0]    r_a_sid;
    logic [VAL_W-1:0]                   r_a_val;

    // list state
    logic [CODE_W-1:0] r_free;
    logic [CODE_W-1:0] r_top [NUM_STACKS];
    logic [CODE_W-1:0] n_free;
    logic [CODE_W-1:0] n_top [NUM_STACKS];

    // response stage
    logic                r_out_vld;
    mssb_pkg::t_status   r_out_status;
    logic [VAL_W-1:0]    r_out_pop;
    mssb_pkg::t_status   n_status;
    logic [VAL_W-1:0]    n_pop;

    logic              acc;
    logic              fire;
    logic [TOP_W-1:0]  a_sel;
    logic [TOP_W-1:0]  b_sel;
    logic              a_in;
    logic [CODE_W-1:0] a_top;
    logic [CODE_W-1:0] a_code;
    logic              a_ok;
    logic [CODE_W-1:0] b_code;
    logic [CODE_W-1:0] link_eff;
    logic [VAL_W-1:0]  data_eff;
    logic              link_we;
    logic [CODE_W-1:0] link_wd;
    logic              data_we;

    assign acc         = i_cmd.valid && i_cmd.ready;
    assign fire        = r_a_vld && (!r_out_vld || o_rsp.ready);
    assign i_cmd.ready = !r_a_vld || fire;

    assign a_sel  = TOP_W'(r_a_sid);
    assign a_in   = int'(r_a_sid) < NUM_STACKS;
    assign a_top  = r_top[a_sel];
    assign a_code = (r_a_cmd == mssb_pkg::CMD_PUSH) ? r_free : a_top;
    assign a_ok   = a_in && (a_code < NULL_CODE);

    always_comb begin
        n_free   = r_free;
        n_top    = r_top;
        link_we  = 1'b0;
        link_wd  = a_top;
        data_we  = 1'b0;
        n_pop    = '0;
        n_status = mssb_pkg::ST_OK;
        unique case (r_a_cmd)
            mssb_pkg::CMD_PUSH: begin
                link_wd = a_top;
                if (a_ok) begin
                    if (fire) begin
                        n_free       = link_eff;
                        n_top[a_sel] = a_code;
                        link_we      = 1'b1;
                        data_we      = 1'b1;
                    end
                end else begin
                    n_status = mssb_pkg::ST_FULL;
                end
            end
            mssb_pkg::CMD_POP: begin
                link_wd = r_free;
                if (a_ok) begin
                    n_pop = data_eff;
                    if (fire) begin
                        n_top[a_sel] = link_eff;
                        n_free       = a_code;
                        link_we      = 1'b1;
                    end
                end else begin
                    n_status = mssb_pkg::ST_EMPTY;
                end
            end
            default: begin
                n_status = mssb_pkg::ST_EMPTY;
            end
        endcase
    end

    // slot of the incoming transaction, seen through this cycle's update
    assign b_sel  = TOP_W'(i_cmd.stack_id);
    assign b_code = (i_cmd.cmd == mssb_pkg::CMD_PUSH) ? n_free : n_top[b_sel];

    mssb_link_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (b_code[IDX_W-1:0]),
        .i_wr_en   (link_we),
        .i_wr_addr (a_code[IDX_W-1:0]),
        .i_wr_data (link_wd),
        .o_rd_data (link_eff)
    );

    mssb_data_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_data (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc),
        .i_rd_addr (b_code[IDX_W-1:0]),
        .i_wr_en   (data_we),
        .i_wr_addr (a_code[IDX_W-1:0]),
        .i_wr_data (r_a_val),
        .o_rd_data (data_eff)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_free    <= '0;
            r_top     <= '{default: NULL_CODE};
        end else begin
            r_free <= n_free;
            r_top  <= n_top;
            if (acc) begin
                r_a_vld <= 1'b1;
            end else if (fire) begin
                r_a_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_cmd <= mssb_pkg::t_cmd'(i_cmd.cmd);
            r_a_sid <= i_cmd.stack_id;
            r_a_val <= i_cmd.push_value;
        end
        if (fire) begin
            r_out_status <= n_status;
            r_out_pop    <= n_pop;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.pop_value = r_out_pop;

    // blocked transaction stays in the command stage
    `MSSB_ASSERT_NEXT(a_cmd_hold, i_clk, i_rst_n, r_a_vld && !fire, r_a_vld && $stable(r_a_val))
    // failed transaction leaves the free list alone
    `MSSB_ASSERT_NEXT(a_fail_keep, i_clk, i_rst_n, fire && !a_ok, $stable(r_free))
    // a good pop puts its slot at the free-list head
    `MSSB_ASSERT_NEXT(a_pop_free, i_clk, i_rst_n, fire && a_ok && r_a_cmd == mssb_pkg::CMD_POP, r_free == $past(a_code))
    // a good push takes the free-list head
    `MSSB_ASSERT_NOW(a_push_slot, i_clk, i_rst_n, data_we, a_code == r_free && a_code < NULL_CODE)

endmodule

/* tb/testbench.sv */
// ============================================================================
// testbench - multi_stack_shared_buffer verification
// Drives push/pop transactions with random gaps and response back-pressure.
// A scoreboard keeps its own model of the stacks, the link store and the free
// list, and checks every response in order. Random traffic runs in fill,
// balanced and drain phases so that the buffer goes both full and empty.
// ============================================================================
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_STACKS   = mssb_pkg::NUM_STACKS_DEF;
    localparam int NUM_SLOTS    = mssb_pkg::NUM_SLOTS_DEF;
    localparam int SID_W        = mssb_pkg::STACK_ID_W;
    localparam int VAL_W        = mssb_pkg::VALUE_W;
    localparam int ST_W         = mssb_pkg::STATUS_W;
    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_PCT     = 26;
    localparam int STALL_LIMIT  = 1000;
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        mssb_pkg::t_status  status;
        logic [VAL_W-1:0]   value;
    } t_reply;

    typedef enum {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } t_mix;

    class stack_ledger;
        logic [VAL_W-1:0]   slot_value [NUM_SLOTS];
        int unsigned        next_slot  [NUM_SLOTS];
        int unsigned        top_slot   [NUM_STACKS];
        int unsigned        free_slot;
        int unsigned        used;
        int unsigned        faults;
        t_reply             owed_replies [$];

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                next_slot[i]  = i + 1;
                slot_value[i] = '0;
            end
            for (i = 0; i < NUM_STACKS; i++) begin
                top_slot[i] = NUM_SLOTS;
            end
            free_slot = 0;
            used      = 0;
            faults    = 0;
        endfunction

        // Predicts the reply of one accepted command and updates the lists.
        function void apply_command(mssb_pkg::t_cmd op, logic [SID_W-1:0] sid,
                                    logic [VAL_W-1:0] value);
            t_reply      reply;
            int unsigned idx;
            reply.status = mssb_pkg::ST_OK;
            reply.value  = '0;
            if (op == mssb_pkg::CMD_PUSH) begin
                if (sid >= NUM_STACKS || free_slot >= NUM_SLOTS) begin
                    reply.status = mssb_pkg::ST_FULL;
                end else begin
                    idx             = free_slot;
                    free_slot       = next_slot[idx];
                    slot_value[idx] = value;
                    next_slot[idx]  = top_slot[sid];
                    top_slot[sid]   = idx;
                    used++;
                end
            end else begin
                if (sid >= NUM_STACKS || top_slot[sid] >= NUM_SLOTS) begin
                    reply.status = mssb_pkg::ST_EMPTY;
                end else begin
                    idx            = top_slot[sid];
                    top_slot[sid]  = next_slot[idx];
                    reply.value    = slot_value[idx];
                    next_slot[idx] = free_slot;
                    free_slot      = idx;
                    used--;
                end
            end
            owed_replies.push_back(reply);
        endfunction

        function void match_response(logic [ST_W-1:0] status,
                                     logic [VAL_W-1:0] value);
            t_reply want;
            if (owed_replies.size() == 0) begin
                $error("response with no command outstanding: status %0d pop_value %08h",
                       status, value);
                faults++;
                return;
            end
            want = owed_replies.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                faults++;
            end
            if (value !== want.value) begin
                $error("pop_value: expected %08h, actual %08h", want.value, value);
                faults++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady = 1'b0;
    int   idle_cycles = 0;

    stack_ledger ledger = new();

    mssb_cmd_if cmd_bus();
    mssb_rsp_if rsp_bus();

    multi_stack_shared_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_command(mssb_pkg::t_cmd op, logic [SID_W-1:0] sid,
                                logic [VAL_W-1:0] value);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            cmd_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid      <= 1'b1;
        cmd_bus.cmd        <= op;
        cmd_bus.stack_id   <= sid;
        cmd_bus.push_value <= value;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        ledger.apply_command(op, sid, value);
        @(negedge i_clk);
    endtask

    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            ledger.match_response(rsp_bus.status, rsp_bus.pop_value);
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("multi_stack_shared_buffer verification failed");
            $finish;
        end
    end

    initial begin
        t_mix                  mode;
        t_mix                  after;
        mssb_pkg::t_cmd        op;
        logic [SID_W-1:0]      sid;
        logic [SID_W-1:0]      favored;
        logic [VAL_W-1:0]      value;
        int                    n;
        int                    spill;
        int                    left;

        i_rst_n            <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.cmd        <= mssb_pkg::CMD_PUSH;
        cmd_bus.stack_id   <= '0;
        cmd_bus.push_value <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pops on empty stacks, extreme values, LIFO order per stack
        for (n = 0; n < NUM_STACKS; n++) send_command(mssb_pkg::CMD_POP, SID_W'(n), '0);
        send_command(mssb_pkg::CMD_PUSH, SID_W'(0), {1'b0, {(VAL_W-1){1'b1}}});
        send_command(mssb_pkg::CMD_PUSH, SID_W'(1), {1'b1, {(VAL_W-1){1'b0}}});
        send_command(mssb_pkg::CMD_PUSH, SID_W'(2), '0);
        send_command(mssb_pkg::CMD_PUSH, SID_W'(3), '1);
        send_command(mssb_pkg::CMD_PUSH, SID_W'(0), 32'h5555_5555);
        send_command(mssb_pkg::CMD_PUSH, SID_W'(0), 32'hAAAA_AAAA);
        for (n = NUM_STACKS - 1; n >= 0; n--) send_command(mssb_pkg::CMD_POP, SID_W'(n), '1);
        send_command(mssb_pkg::CMD_POP, SID_W'(0), '0);
        send_command(mssb_pkg::CMD_POP, SID_W'(0), '0);
        send_command(mssb_pkg::CMD_POP, SID_W'(0), '0);

        // random traffic: fill until full, balanced, drain until empty, balanced
        mode    = MIX_FILL;
        after   = MIX_DRAIN;
        spill   = 0;
        left    = 0;
        favored = SID_W'($urandom_range(NUM_STACKS - 1));
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 250 && n < 370);
            case (mode)
                MIX_FILL:  op = ($urandom_range(99) < 85) ? mssb_pkg::CMD_PUSH
                                                          : mssb_pkg::CMD_POP;
                MIX_DRAIN: op = ($urandom_range(99) < 85) ? mssb_pkg::CMD_POP
                                                          : mssb_pkg::CMD_PUSH;
                default:   op = $urandom_range(1) ? mssb_pkg::CMD_POP : mssb_pkg::CMD_PUSH;
            endcase
            sid = $urandom_range(1) ? favored : SID_W'($urandom_range(NUM_STACKS - 1));
            case ($urandom_range(7))
                0:       value = {1'b0, {(VAL_W-1){1'b1}}};
                1:       value = {1'b1, {(VAL_W-1){1'b0}}};
                2:       value = '0;
                3:       value = '1;
                default: value = $urandom();
            endcase
            send_command(op, sid, value);

            case (mode)
                MIX_FILL: begin
                    if (ledger.used == NUM_SLOTS) spill++;
                    if (spill > 3) begin
                        mode  = MIX_BALANCED;
                        after = MIX_DRAIN;
                        left  = 30;
                        spill = 0;
                    end
                end
                MIX_DRAIN: begin
                    if (ledger.used == 0) spill++;
                    if (spill > 3) begin
                        mode  = MIX_BALANCED;
                        after = MIX_FILL;
                        left  = 30;
                        spill = 0;
                    end
                end
                default: begin
                    left--;
                    if (left == 0) begin
                        mode    = after;
                        favored = SID_W'($urandom_range(NUM_STACKS - 1));
                    end
                end
            endcase
        end
        steady = 1'b0;
        cmd_bus.valid <= 1'b0;

        while (ledger.owed_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (ledger.faults == 0) begin
            $display("multi_stack_shared_buffer verification clean");
        end else begin
            $display("multi_stack_shared_buffer verification failed");
        end
        $finish;
    end
endmodule
